// File: hdl/mlpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multi-level priority queue
// Item formats, status codes, controller command and status groups.
// ----------------------------------------------------------------------------
package mlpq_pkg;

	localparam int LEVELS_DEF      = 8;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 16;

	localparam int          LVL_REG_W     = 4;
	localparam logic [3:0]  LVL_REG_RESET = 4'd8;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic               op;
		logic signed [15:0] value;
		logic [3:0]         priority_req;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] data_out;
		logic [2:0]         served_level;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic capture;
	} ctrl_cmd_t;

	typedef struct packed {
		logic deq_hit;
	} dp_status_t;

endpackage

// File: hdl/mlpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_dp: datapath of the multi-level priority queue
// Per-level pointers and counts, shared entry memory, result register.
// ----------------------------------------------------------------------------
module mlpq_dp
	import mlpq_pkg::*;
#(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [LVL_REG_W-1:0] cfg_wr_data,
	input  in_item_t             in_data,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           dp_stat,
	output out_item_t            res
);

	localparam int LIDX_W = $clog2(LEVELS);
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);

	logic [LVL_REG_W-1:0] lvl_in_use_q;
	in_item_t             item_q;
	logic [CNT_W-1:0]     count_q [LEVELS];
	logic [PTR_W-1:0]     head_q  [LEVELS];
	logic [PTR_W-1:0]     tail_q  [LEVELS];
	logic [DATA_WIDTH-1:0] mem    [LEVELS*LEVEL_DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	out_item_t            res_q;

	logic [4:0]        n_active;
	logic [4:0]        prio5;
	logic              enq_invalid;
	logic [LIDX_W-1:0] enq_lv;
	logic              enq_full;
	logic              enq_do;
	logic              deq_found;
	logic [LIDX_W-1:0] deq_lv;
	logic              deq_do;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic signed [DATA_WIDTH-1:0] wr_word;
	logic signed [DATA_WIDTH-1:0] rd_word;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		n_active = (5'(lvl_in_use_q) > 5'(LEVELS)) ? 5'(LEVELS) : 5'(lvl_in_use_q);
		prio5       = 5'(item_q.priority_req);
		enq_invalid = (item_q.priority_req == '0) || (prio5 > n_active);
		enq_lv      = LIDX_W'(item_q.priority_req - 4'd1);
		enq_full    = (count_q[enq_lv] == CNT_W'(LEVEL_DEPTH));
		enq_do      = cmd.exec && (item_q.op == OP_ENQ) && !enq_invalid && !enq_full;
		deq_found   = 1'b0;
		deq_lv      = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (!deq_found && (5'(i) < n_active) && (count_q[i] != '0)) begin
				deq_found = 1'b1;
				deq_lv    = LIDX_W'(i);
			end
		end
		deq_do  = cmd.exec && (item_q.op == OP_DEQ) && deq_found;
		wr_addr = ADDR_W'(enq_lv * LEVEL_DEPTH) + ADDR_W'(tail_q[enq_lv]);
		rd_addr = ADDR_W'(deq_lv * LEVEL_DEPTH) + ADDR_W'(head_q[deq_lv]);
		wr_word = DATA_WIDTH'(item_q.value);
		rd_word = rd_q;
	end

	assign dp_stat.deq_hit = (item_q.op == OP_DEQ) && deq_found;
	assign res             = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_in_use_q <= LVL_REG_RESET;
			for (int i = 0; i < LEVELS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				lvl_in_use_q <= cfg_wr_data;
			end
			if (enq_do) begin
				tail_q[enq_lv]  <= ptr_next(tail_q[enq_lv]);
				count_q[enq_lv] <= count_q[enq_lv] + 1'b1;
			end
			if (deq_do) begin
				head_q[deq_lv]  <= ptr_next(head_q[deq_lv]);
				count_q[deq_lv] <= count_q[deq_lv] - 1'b1;
			end
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (enq_do) begin
			mem[wr_addr] <= wr_word;
		end
		if (deq_do) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.exec) begin
			res_q.data_out     <= '0;
			res_q.served_level <= '0;
			if (item_q.op == OP_ENQ) begin
				res_q.status <= enq_invalid ? ST_INVALID : (enq_full ? ST_FULL : ST_OK);
			end else if (deq_found) begin
				res_q.status       <= ST_OK;
				res_q.served_level <= 3'(deq_lv);
			end else begin
				res_q.status <= ST_EMPTY;
			end
		end
		if (cmd.capture) begin
			res_q.data_out <= 16'(rd_word);
		end
	end

endmodule

// File: hdl/mlpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpq_ctrl: controller of the multi-level priority queue
// Sequences capture, execute, memory read-back and result transfer.
// ----------------------------------------------------------------------------
module mlpq_ctrl
	import mlpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t dp_stat,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt   = state_q;
		cmd.load    = 1'b0;
		cmd.exec    = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = dp_stat.deq_hit ? S_LOAD : S_OUT;
			end
			S_LOAD: begin
				cmd.capture = 1'b1;
				state_nxt   = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: hdl/multi_level_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_level_priority_queue: strict-priority queue, one FIFO per level
// Enqueue to a level's FIFO, dequeue the oldest entry of the best level.
// ----------------------------------------------------------------------------
// The queue handles one item at a time. An enqueue, or any rejected or empty
// operation, passes through capture in the cycle of its input transfer, then
// execute and present; a successful dequeue adds a read-back step, because the
// single read port of the shared entry memory returns its data in the cycle
// after the address. The next item is taken in the cycle after its result
// transfers. Priority 1 is the highest level; an enqueue with priority 0 or
// above levels_in_use returns status invalid, an enqueue into a level holding
// LEVEL_DEPTH entries returns full, and a dequeue with every level in use
// empty returns empty. levels_in_use values above LEVELS act as LEVELS;
// lowering it hides, but keeps, the data of upper levels. Write cfg_wr_data
// only while the queue is idle. Reset clears all pointers and counts at once,
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_level_priority_queue
	import mlpq_pkg::*;
#(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [LVL_REG_W-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	// command and status groups between controller and datapath
	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_stat;

	// controller: hold the input side stalled while an item is in flight
	mlpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_stat   (dp_stat),
		.cmd       (ctrl_cmd)
	);

	// datapath: level bookkeeping, entry memory and the result register
	mlpq_dp #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (ctrl_cmd),
		.dp_stat     (dp_stat),
		.res         (out_data)
	);

	// an input transfer never overlaps a pending result
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("input transfer while a result is pending");

	// after the execute step that follows an input transfer, the result is either presented or being loaded
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##2 (out_valid || ctrl_cmd.capture))
		else $error("result not ready in time");

	// a result transfer frees the input side in the next cycle
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !in_stall)
		else $error("input side not released after result transfer");

	// memory read-back only follows an execute step that found data
	a_capture_src: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.capture |-> $past(ctrl_cmd.exec) && $past(dp_stat.deq_hit))
		else $error("read-back without a dequeue hit");

endmodule
